FILE: hw/rtl/cp2u8_pkg.sv
// Shared types, constants and the upper-half code page table for the
// Windows-1251 to UTF-8 transcoder. No dependencies.

package cp2u8_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxBytes = 3;
  localparam int unsigned CountW   = 2;
  localparam int unsigned WordW    = MaxBytes * ByteW;

  // Bit that separates ASCII from the code page's upper half.
  localparam int unsigned HiBit = ByteW - 1;

  // One decoded character: its UTF-8 bytes, first byte in the lowest slot,
  // and how many of them are sent (zero for an unmapped code).
  typedef struct packed {
    logic [CountW-1:0]                nbytes;
    logic [MaxBytes-1:0][ByteW-1:0]   bytes;
  } char_t;

  // UTF-8 encodings of 0x80..0xFF, least significant byte sent first.
  // A zero word marks the one code point with no character.
  localparam logic [WordW-1:0] HiMap [128] = '{
    24'h0082D0, 24'h0083D0, 24'h9A80E2, 24'h0093D1,
    24'h9E80E2, 24'hA680E2, 24'hA080E2, 24'hA180E2,
    24'hAC82E2, 24'hB080E2, 24'h0089D0, 24'hB980E2,
    24'h008AD0, 24'h008CD0, 24'h008BD0, 24'h008FD0,
    24'h0092D1, 24'h9880E2, 24'h9980E2, 24'h9C80E2,
    24'h9D80E2, 24'hA280E2, 24'h9380E2, 24'h9480E2,
    24'h000000, 24'hA284E2, 24'h0099D1, 24'hBA80E2,
    24'h009AD1, 24'h009CD1, 24'h009BD1, 24'h009FD1,
    24'h00A0C2, 24'h008ED0, 24'h009ED1, 24'h0088D0,
    24'h00A4C2, 24'h0090D2, 24'h00A6C2, 24'h00A7C2,
    24'h0081D0, 24'h00A9C2, 24'h0084D0, 24'h00ABC2,
    24'h00ACC2, 24'h00ADC2, 24'h00AEC2, 24'h0087D0,
    24'h00B0C2, 24'h00B1C2, 24'h0086D0, 24'h0096D1,
    24'h0091D2, 24'h00B5C2, 24'h00B6C2, 24'h00B7C2,
    24'h0091D1, 24'h9684E2, 24'h0094D1, 24'h00BBC2,
    24'h0098D1, 24'h0085D0, 24'h0095D1, 24'h0097D1,
    24'h0090D0, 24'h0091D0, 24'h0092D0, 24'h0093D0,
    24'h0094D0, 24'h0095D0, 24'h0096D0, 24'h0097D0,
    24'h0098D0, 24'h0099D0, 24'h009AD0, 24'h009BD0,
    24'h009CD0, 24'h009DD0, 24'h009ED0, 24'h009FD0,
    24'h00A0D0, 24'h00A1D0, 24'h00A2D0, 24'h00A3D0,
    24'h00A4D0, 24'h00A5D0, 24'h00A6D0, 24'h00A7D0,
    24'h00A8D0, 24'h00A9D0, 24'h00AAD0, 24'h00ABD0,
    24'h00ACD0, 24'h00ADD0, 24'h00AED0, 24'h00AFD0,
    24'h00B0D0, 24'h00B1D0, 24'h00B2D0, 24'h00B3D0,
    24'h00B4D0, 24'h00B5D0, 24'h00B6D0, 24'h00B7D0,
    24'h00B8D0, 24'h00B9D0, 24'h00BAD0, 24'h00BBD0,
    24'h00BCD0, 24'h00BDD0, 24'h00BED0, 24'h00BFD0,
    24'h0080D1, 24'h0081D1, 24'h0082D1, 24'h0083D1,
    24'h0084D1, 24'h0085D1, 24'h0086D1, 24'h0087D1,
    24'h0088D1, 24'h0089D1, 24'h008AD1, 24'h008BD1,
    24'h008CD1, 24'h008DD1, 24'h008ED1, 24'h008FD1
  };

endpackage

FILE: hw/rtl/cp2u8_decode.sv
// Input register and code page lookup for the Windows-1251 to UTF-8
// transcoder. Depends on cp2u8_pkg.

module cp2u8_decode
  import cp2u8_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             char_valid_o,
  input  logic             char_ready_i,
  output char_t            char_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic [WordW-1:0] word;

  // The register takes a new request when empty or when its content moves on.
  assign in_ready_o = !valid_q || char_ready_i;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      byte_d  = in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign word = HiMap[byte_q[HiBit-1:0]];

  always_comb begin
    char_o = '0;
    if (!byte_q[HiBit]) begin
      char_o.nbytes   = CountW'(1);
      char_o.bytes[0] = byte_q;
    end else begin
      char_o.bytes = word;
      if (word == '0) begin
        char_o.nbytes = CountW'(0);
      end else if (word[WordW-1 -: ByteW] == '0) begin
        char_o.nbytes = CountW'(2);
      end else begin
        char_o.nbytes = CountW'(3);
      end
    end
  end

  assign char_valid_o = valid_q;

endmodule

FILE: hw/rtl/cp2u8_serial.sv
// Output register that sends one decoded character as one to three UTF-8
// bytes, one per cycle while out_ready_i is high. Depends on cp2u8_pkg.

module cp2u8_serial
  import cp2u8_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             char_valid_i,
  output logic             char_ready_o,
  input  char_t            char_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             out_last_o
);

  logic              valid_q, valid_d;
  char_t             char_q, char_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic              fire;

  assign out_byte_o  = char_q.bytes[idx_q];
  assign out_last_o  = (idx_q == char_q.nbytes - CountW'(1));
  assign out_valid_o = valid_q;
  assign fire        = valid_q && out_ready_i;

  // A new character loads when the register is empty or its last byte leaves.
  assign char_ready_o = !valid_q || (fire && out_last_o);

  always_comb begin
    valid_d = valid_q;
    char_d  = char_q;
    idx_d   = idx_q;
    if (char_ready_o) begin
      // An unmapped code has no bytes and is dropped here.
      valid_d = char_valid_i && (char_i.nbytes != '0);
      char_d  = char_i;
      idx_d   = '0;
    end else if (fire) begin
      idx_d = idx_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

endmodule

FILE: hw/rtl/cp1251_to_utf8_transcoder.sv
// Top level of the Windows-1251 to UTF-8 transcoder.
// Depends on cp2u8_pkg, cp2u8_decode and cp2u8_serial.

// The block takes one Windows-1251 byte per request on the slave stream and
// sends its UTF-8 encoding on the master stream, one byte per request, with
// tlast set on the final byte of each character. ASCII bytes pass through as
// a single byte, the upper half of the code page becomes two or three bytes
// from a constant 128-entry table, and 0x98, which has no character, yields
// nothing at all. A byte is taken into an input register in any cycle in
// which that register is empty or hands its character on; the character is
// looked up there and moves into the output register, which sends one byte
// per cycle while m_axis_tready is high. A character's first byte is offered
// only after the input register and then the output register have taken it.
// The output register sets the rate: it sends a character's UTF-8 bytes one
// at a time and takes the next character as the last one leaves, so ASCII
// streams at one character per cycle when the output is not stalled, while
// the input register already holds the next character. The block keeps no
// state between characters.

module cp1251_to_utf8_transcoder
  import cp2u8_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,  // [7:0] source_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [ByteW-1:0] m_axis_tdata,  // [7:0] utf8_byte
  output logic             m_axis_tlast   // last_byte
);

  logic  char_valid;
  logic  char_ready;
  char_t char_data;

  cp2u8_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .char_valid_o (char_valid),
    .char_ready_i (char_ready),
    .char_o       (char_data)
  );

  cp2u8_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (char_valid),
    .char_ready_o (char_ready),
    .char_i       (char_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

FILE: hw/rtl/cp2u8_checker.sv
// Port-level checks for the Windows-1251 to UTF-8 transcoder, bound to its
// top level. Depends on cp2u8_pkg.

module cp2u8_checker
  import cp2u8_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [ByteW-1:0] s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [ByteW-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  // A waiting input request holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input request changed while waiting");

  // A stalled output byte holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output request changed while stalled");

  // A character continues without a gap, and with a continuation byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tdata[7:6] == 2'b10))
    else $error("character broken off or bad continuation byte");

  // An ASCII byte always stands alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[HiBit] |-> m_axis_tlast)
    else $error("ASCII byte not marked last");

  // A three-byte lead never ends a character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata == 8'hE2) |-> !m_axis_tlast)
    else $error("lead byte marked last");

endmodule

bind cp1251_to_utf8_transcoder cp2u8_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
